/* src/bdpl_pkg.sv */
// shared constants and types for the button debouncer with press latch
// no dependencies; imported by the interfaces, the top level, the checker and the bench
package bdpl_pkg;

	localparam int BUTTONS   = 3;
	localparam int TIME_BITS = 32;
	localparam int DEB_BITS  = 16;
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 3;
	localparam int IDX_BITS  = ADDR_BITS - 2;

	localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = DEB_BITS'(50);
	localparam logic [IDX_BITS-1:0] REG_DEBOUNCE   = IDX_BITS'(0);

	typedef enum logic [2:0] {
		PH_RELEASED = 3'b001,
		PH_PRESSED  = 3'b010,
		PH_CONSUMED = 3'b100
	} phase_t;

endpackage

/* src/bdpl_if.sv */
// valid/ready channels for sample beats and press event beats
// depends on bdpl_pkg
interface bdpl_item_if;
	import bdpl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 sample_valid;
	logic [TIME_BITS-1:0] now_ms;
	logic [BUTTONS-1:0]   raw_levels;
	logic [BUTTONS-1:0]   read_mask;

	modport source (output valid, output sample_valid, output now_ms,
		output raw_levels, output read_mask, input ready);
	modport sink (input valid, input sample_valid, input now_ms,
		input raw_levels, input read_mask, output ready);
endinterface

interface bdpl_result_if;
	import bdpl_pkg::*;

	logic               valid;
	logic               ready;
	logic [BUTTONS-1:0] press_events;

	modport source (output valid, output press_events, input ready);
	modport sink (input valid, input press_events, output ready);
endinterface

/* src/button_debounce_press_latch.sv */
// path: an accepted beat goes through the input register, then the result
// register, to its result beat; it waits there while the result side stalls
// throughput: one beat per cycle while the result side takes beats; all button updates are one compare stage
// reset: arst_n clears levels, time stamps and phases (all released),
// debounce_ms returns to 50 and both pipeline registers are emptied
// depends on bdpl_pkg and bdpl_if
module button_debounce_press_latch (
	input  logic                               clk,
	input  logic                               arst_n,
	bdpl_item_if.sink                          item,
	bdpl_result_if.source                      result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bdpl_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [bdpl_pkg::DATA_BITS-1:0]     pwdata,
	output logic [bdpl_pkg::DATA_BITS-1:0]     prdata,
	output logic                               pready
);
	import bdpl_pkg::*;

	logic [DEB_BITS-1:0]  debounce_q;

	logic                 vld_s1;
	logic                 smp_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [BUTTONS-1:0]   lvl_s1;
	logic [BUTTONS-1:0]   mask_s1;

	logic                 res_vld_q;
	logic [BUTTONS-1:0]   res_ev_q;

	logic [BUTTONS-1:0]   seen_q;
	logic [TIME_BITS-1:0] ptime_q [BUTTONS];
	logic [TIME_BITS-1:0] rtime_q [BUTTONS];
	phase_t               phase_q [BUTTONS];

	logic [BUTTONS-1:0]   seen_n;
	logic [TIME_BITS-1:0] ptime_n [BUTTONS];
	logic [TIME_BITS-1:0] rtime_n [BUTTONS];
	phase_t               phase_n [BUTTONS];
	logic [BUTTONS-1:0]   ev_n;
	logic [BUTTONS-1:0]   held_hi;
	logic [BUTTONS-1:0]   held_lo;

	logic                 advance;
	logic                 fire;
	logic                 cfg_wr;
	logic [TIME_BITS-1:0] deb_ext;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite
		&& (paddr[ADDR_BITS-1:2] == REG_DEBOUNCE);
	assign prdata  = (paddr[ADDR_BITS-1:2] == REG_DEBOUNCE)
		? DATA_BITS'(debounce_q) : '0;
	assign deb_ext = TIME_BITS'(debounce_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_wr) begin
			debounce_q <= pwdata[DEB_BITS-1:0];
		end
	end

	// result register frees up when empty or being taken
	assign advance    = !res_vld_q || result.ready;
	assign item.ready = !vld_s1 || advance;
	assign fire       = vld_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			smp_s1  <= item.sample_valid;
			now_s1  <= item.now_ms;
			lvl_s1  <= item.raw_levels;
			mask_s1 <= item.read_mask;
		end
	end

	always_comb begin
		for (int i = 0; i < BUTTONS; i++) begin
			seen_n[i]  = seen_q[i];
			ptime_n[i] = ptime_q[i];
			rtime_n[i] = rtime_q[i];
			phase_n[i] = phase_q[i];
			ev_n[i]    = 1'b0;
			if (smp_s1) begin
				seen_n[i] = lvl_s1[i];
				if (lvl_s1[i] && !seen_q[i]) begin
					ptime_n[i] = now_s1;
				end
				if (!lvl_s1[i] && seen_q[i]) begin
					rtime_n[i] = now_s1;
				end
			end
			// wrap-safe elapsed time, strictly longer than the hold time
			held_hi[i] = (now_s1 - ptime_n[i]) > deb_ext;
			held_lo[i] = (now_s1 - rtime_n[i]) > deb_ext;
			if (smp_s1) begin
				if (phase_q[i] == PH_RELEASED && seen_n[i] && held_hi[i]) begin
					phase_n[i] = PH_PRESSED;
				end
				if (!seen_n[i] && held_lo[i]) begin
					phase_n[i] = PH_RELEASED;
				end
			end
			if (mask_s1[i] && phase_n[i] == PH_PRESSED) begin
				ev_n[i]    = 1'b1;
				phase_n[i] = PH_CONSUMED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < BUTTONS; i++) begin
				ptime_q[i] <= '0;
				rtime_q[i] <= '0;
				phase_q[i] <= PH_RELEASED;
			end
		end else if (fire) begin
			seen_q <= seen_n;
			for (int i = 0; i < BUTTONS; i++) begin
				ptime_q[i] <= ptime_n[i];
				rtime_q[i] <= rtime_n[i];
				phase_q[i] <= phase_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_ev_q <= ev_n;
		end
	end

	assign result.valid        = res_vld_q;
	assign result.press_events = res_ev_q;

endmodule

/* src/bdpl_checker.sv */
// port-level checks for button_debounce_press_latch, bound to the top level
// depends on bdpl_pkg and bdpl_if
module bdpl_checker (
	input logic                               clk,
	input logic                               arst_n,
	bdpl_item_if.sink                         item,
	bdpl_result_if.source                     result,
	input logic                               psel,
	input logic                               penable,
	input logic                               pwrite,
	input logic [bdpl_pkg::ADDR_BITS-1:0]     paddr,
	input logic [bdpl_pkg::DATA_BITS-1:0]     pwdata,
	input logic [bdpl_pkg::DATA_BITS-1:0]     prdata,
	input logic                               pready
);
	import bdpl_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.press_events))
		else $error("result beat dropped or changed while stalled");

	// nothing comes out right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !result.valid)
		else $error("result beat right after reset");

	// a written hold time reads back
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[ADDR_BITS-1:2] == REG_DEBOUNCE)
		##1 (paddr[ADDR_BITS-1:2] == REG_DEBOUNCE)
		|-> prdata == DATA_BITS'($past(pwdata[DEB_BITS-1:0])))
		else $error("debounce register readback mismatch");

	// with an empty result register the input side is never held off
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid && !$past(item.valid && item.ready) |-> item.ready)
		else $error("input stalled with empty pipeline");

endmodule

bind button_debounce_press_latch bdpl_checker u_bdpl_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.item    (item),
	.result  (result),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pready  (pready)
);

/* tb/sv/tb_button_debounce_press_latch.sv */
`timescale 1ns / 1ps
// self-checking bench for button_debounce_press_latch: directed table, then random sample beats
// depends on bdpl_pkg, bdpl_item_if / bdpl_result_if and the top level
module tb_button_debounce_press_latch;
	import bdpl_pkg::*;

	localparam logic [IDX_BITS-1:0]  REG_UNMAPPED  = IDX_BITS'(1);
	localparam logic [ADDR_BITS-1:0] ADDR_DEBOUNCE = {REG_DEBOUNCE, 2'b00};
	localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED = {REG_UNMAPPED, 2'b00};
	localparam int NO_WRITE = -1;

	typedef struct {
		logic                 sample_valid;
		logic [TIME_BITS-1:0] now_ms;
		logic [BUTTONS-1:0]   raw_levels;
		logic [BUTTONS-1:0]   read_mask;
	} sample_t;

	typedef struct {
		int                 hold;
		sample_t            s;
		bit                 typed;
		logic [BUTTONS-1:0] want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	bdpl_item_if   item_ch ();
	bdpl_result_if result_ch ();

	button_debounce_press_latch u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// debounce predictor state
	logic [DEB_BITS-1:0]  hold_ms;
	logic [BUTTONS-1:0]   seen_lvl;
	logic [TIME_BITS-1:0] t_rise [BUTTONS];
	logic [TIME_BITS-1:0] t_fall [BUTTONS];
	phase_t               btn_state [BUTTONS];

	logic [BUTTONS-1:0] press_q [$];
	row_t               plan [$];
	int errors = 0;
	int n_beats = 0;
	int n_results = 0;
	int n_writes = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;

	task automatic report_err(input string what);
		errors++;
		if (errors <= 40)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	function automatic bit held_past(input logic [TIME_BITS-1:0] now,
		input logic [TIME_BITS-1:0] since);
		logic [TIME_BITS-1:0] gap;
		gap = now - since;
		return gap > TIME_BITS'(hold_ms);
	endfunction

	function automatic logic [BUTTONS-1:0] debounce_step(input sample_t s);
		logic [BUTTONS-1:0] events;
		events = '0;
		if (s.sample_valid) begin
			for (int b = 0; b < BUTTONS; b++) begin
				if (s.raw_levels[b] && !seen_lvl[b]) begin
					seen_lvl[b] = 1'b1;
					t_rise[b] = s.now_ms;
				end else if (!s.raw_levels[b] && seen_lvl[b]) begin
					seen_lvl[b] = 1'b0;
					t_fall[b] = s.now_ms;
				end
				if (btn_state[b] == PH_RELEASED && seen_lvl[b] && held_past(s.now_ms, t_rise[b]))
					btn_state[b] = PH_PRESSED;
				// release is tried last so it wins
				if (!seen_lvl[b] && held_past(s.now_ms, t_fall[b]))
					btn_state[b] = PH_RELEASED;
			end
		end
		for (int b = 0; b < BUTTONS; b++) begin
			if (s.read_mask[b] && btn_state[b] == PH_PRESSED) begin
				events[b] = 1'b1;
				btn_state[b] = PH_CONSUMED;
			end
		end
		return events;
	endfunction

	task automatic push_beat(input sample_t s, input bit typed, input logic [BUTTONS-1:0] typed_val);
		logic [BUTTONS-1:0] want;
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.sample_valid <= s.sample_valid;
		item_ch.now_ms       <= s.now_ms;
		item_ch.raw_levels   <= s.raw_levels;
		item_ch.read_mask    <= s.read_mask;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		want = debounce_step(s);
		if (typed)
			want = typed_val;
		press_q.push_back(want);
		n_beats++;
	endtask

	// holds the sender until every expected beat has come back
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (press_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr[ADDR_BITS-1:2] == REG_DEBOUNCE)
			hold_ms = data[DEB_BITS-1:0];
		n_writes++;
		@(posedge clk);
	endtask

	task automatic reg_check(input logic [ADDR_BITS-1:0] addr);
		logic [DATA_BITS-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== DATA_BITS'(hold_ms))
			report_err($sformatf("debounce_ms reads 0x%0h, expected 0x%0h", got, hold_ms));
		@(posedge clk);
	endtask

	task automatic set_hold(input logic [DEB_BITS-1:0] v);
		drain_results();
		reg_write(ADDR_DEBOUNCE, {(DATA_BITS - DEB_BITS)'($urandom()), v});
		reg_check(ADDR_DEBOUNCE);
	endtask

	task automatic plan_row(input int hold, input logic sv, input logic [TIME_BITS-1:0] now,
		input logic [BUTTONS-1:0] raw, input logic [BUTTONS-1:0] mask, input bit typed,
		input logic [BUTTONS-1:0] want);
		row_t r;
		r.hold           = hold;
		r.s.sample_valid = sv;
		r.s.now_ms       = now;
		r.s.raw_levels   = raw;
		r.s.read_mask    = mask;
		r.typed          = typed;
		r.want           = want;
		plan.push_back(r);
	endtask

	// result side: random back-pressure and in-order comparison
	initial begin : result_sink
		logic [BUTTONS-1:0] want;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				n_results++;
				if (press_q.size() == 0) begin
					report_err($sformatf("press beat 0x%0h with nothing expected",
						result_ch.press_events));
				end else begin
					want = press_q.pop_front();
					if (result_ch.press_events !== want)
						report_err($sformatf("press_events 0x%0h, expected 0x%0h",
							result_ch.press_events, want));
				end
			end
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb_button_debounce_press_latch: errors");
		$finish;
	end

	initial begin : stimulus
		sample_t              s;
		logic [DEB_BITS-1:0]  hold_plan [9];
		logic [TIME_BITS-1:0] clock_ms;
		logic [TIME_BITS-1:0] step;
		logic [BUTTONS-1:0]   lvl;

		item_ch.valid        <= 1'b0;
		item_ch.sample_valid <= 1'b0;
		item_ch.now_ms       <= '0;
		item_ch.raw_levels   <= '0;
		item_ch.read_mask    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;

		hold_ms  = DEBOUNCE_RESET;
		seen_lvl = '0;
		for (int b = 0; b < BUTTONS; b++) begin
			t_rise[b]    = '0;
			t_fall[b]    = '0;
			btn_state[b] = PH_RELEASED;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 33;
		snk_idle_pct = 85;

		// default hold of 50 ms, rising edges just before the counter wraps
		plan_row(NO_WRITE, 1'b0, 32'h0000_0000, 3'b000, 3'b111, 1, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'hFFFF_FFF0, 3'b111, 3'b111, 1, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_0022, 3'b111, 3'b111, 1, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_0023, 3'b111, 3'b001, 1, 3'b001);
		plan_row(NO_WRITE, 1'b0, 32'h0000_0000, 3'b000, 3'b010, 1, 3'b010);
		plan_row(NO_WRITE, 1'b0, 32'hFFFF_FFFF, 3'b000, 3'b111, 1, 3'b100);
		plan_row(NO_WRITE, 1'b1, 32'h0000_0030, 3'b000, 3'b111, 1, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_0062, 3'b000, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_0063, 3'b000, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_0070, 3'b111, 3'b000, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_00A3, 3'b101, 3'b000, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_00A4, 3'b111, 3'b111, 0, 3'b000);
		// zero hold: one millisecond is still needed
		plan_row(0,        1'b1, 32'h0000_1000, 3'b010, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_1000, 3'b000, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_1001, 3'b000, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_1001, 3'b111, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0000_1002, 3'b111, 3'b111, 1, 3'b111);
		// largest hold
		plan_row(65535,    1'b1, 32'h0000_1002, 3'b000, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0001_1001, 3'b000, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0001_1002, 3'b000, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0001_1002, 3'b111, 3'b111, 0, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0002_1002, 3'b111, 3'b111, 1, 3'b111);
		plan_row(NO_WRITE, 1'b0, 32'h0000_0000, 3'b000, 3'b111, 1, 3'b000);
		plan_row(NO_WRITE, 1'b1, 32'h0002_1003, 3'b111, 3'b111, 1, 3'b000);

		foreach (plan[i]) begin
			if (plan[i].hold != NO_WRITE)
				set_hold(DEB_BITS'(plan[i].hold));
			push_beat(plan[i].s, plan[i].typed, plan[i].want);
		end

		// a write to an unmapped index must leave debounce_ms alone
		drain_results();
		reg_write(ADDR_UNMAPPED, $urandom());
		reg_check(ADDR_DEBOUNCE);

		hold_plan = '{16'd0, 16'd1, 16'd50, 16'd65535, 16'd7, 16'd300, 16'd3, 16'd65534, 16'd12};
		for (int seg = 0; seg < 9; seg++) begin
			src_idle_pct = (seg < 3) ? 33 : (seg < 6) ? 85 : 0;
			snk_idle_pct = (seg < 3) ? 85 : (seg < 6) ? 33 : 0;
			set_hold(hold_plan[seg]);
			lvl = BUTTONS'($urandom());
			if (seg % 2 == 1)
				clock_ms = $urandom();
			else
				clock_ms = 32'hFFFF_FFFF - TIME_BITS'($urandom_range(4 * int'(hold_ms) + 100));

			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(99) == 0)
					drain_results();
				if ($urandom_range(99) < 8) begin
					// noise beat
					s.sample_valid = 1'($urandom());
					s.now_ms       = $urandom();
					s.raw_levels   = BUTTONS'($urandom());
					s.read_mask    = BUTTONS'($urandom());
				end else begin
					case ($urandom_range(5))
						0: step = '0;
						1: step = 1;
						2: step = TIME_BITS'(hold_ms);
						3: step = TIME_BITS'(hold_ms) + 1;
						4: step = TIME_BITS'($urandom_range(2 * int'(hold_ms) + 2));
						default: step = TIME_BITS'($urandom_range(int'(hold_ms) / 4 + 1));
					endcase
					if ($urandom_range(49) == 0)
						step = $urandom();
					clock_ms += step;
					for (int b = 0; b < BUTTONS; b++)
						if ($urandom_range(3) == 0)
							lvl[b] = ~lvl[b];
					s.sample_valid = ($urandom_range(9) != 0);
					s.now_ms       = s.sample_valid ? clock_ms : $urandom();
					s.raw_levels   = s.sample_valid ? lvl : BUTTONS'($urandom());
					s.read_mask    = BUTTONS'($urandom());
				end
				push_beat(s, 0, '0);
			end
		end

		drain_results();
		$display("run covered %0d sample beats and %0d press beats, %0d register writes,",
			n_beats, n_results, n_writes);
		$display("hold times from 0 to 65535 ms, counter wrap and three back-pressure mixes");
		if (errors == 0) begin
			$display("tb_button_debounce_press_latch: clean");
		end else begin
			$display("tb_button_debounce_press_latch: errors");
		end
		$finish;
	end

endmodule

/* files.f */
src/bdpl_pkg.sv
src/bdpl_if.sv
src/button_debounce_press_latch.sv
src/bdpl_checker.sv
tb/sv/tb_button_debounce_press_latch.sv
